>>> rtl/ctmc_pkg.sv
package ctmc_pkg;

  // valid calendar span
  localparam logic [11:0] YEAR_FIRST = 12'd1601;
  localparam logic [11:0] YEAR_LAST  = 12'd2400;

  // weights
  localparam logic [18:0] DAYS_PER_YEAR = 19'd365;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] DAY_SECONDS   = 17'd86400;
  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;

  localparam int DAYS_W = 19;
  localparam int TOD_W  = 17;
  localparam int SECS_W = 35;
  localparam int SLO_W  = 18;
  localparam int SHI_W  = SECS_W - SLO_W;
  localparam int STAMP_W = 55;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
  } date_t;

  // day count stage to seconds stage
  typedef struct packed {
    logic              vld;
    logic              bad;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
    logic [19:0]       micro;
  } day_req_t;

  // seconds stage to microsecond scaling stage
  typedef struct packed {
    logic              vld;
    logic              bad;
    logic [SECS_W-1:0] secs;
    logic [19:0]       micro;
  } sec_req_t;

  // days before the first of the month, non-leap year
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] off;
    case (month)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> rtl/ctmc_in_if.sv
interface ctmc_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [19:0] micro;

  modport source (output valid, year, month, day, hour, minute, second, micro,
                  input ready);
  modport sink (input valid, year, month, day, hour, minute, second, micro,
                output ready);
endinterface

>>> rtl/ctmc_out_if.sv
interface ctmc_out_if;
  logic        valid;
  logic        ready;
  logic [54:0] stamp;
  logic        invalid;

  modport source (output valid, stamp, invalid, input ready);
  modport sink (input valid, stamp, invalid, output ready);
endinterface

>>> rtl/ctmc_days.sv
module ctmc_days (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_vld,
  output logic              up_rdy,
  input  ctmc_pkg::date_t   date,
  output ctmc_pkg::day_req_t dn,
  input  logic              dn_rdy
);
  import ctmc_pkg::*;

  // stage 1: range check and split of the date
  logic        s1_vld;
  logic        s1_bad;
  logic [9:0]  s1_yo;
  logic [8:0]  s1_doy;
  logic [7:0]  s1_leaps;
  logic [TOD_W-1:0] s1_tod;
  logic [19:0] s1_micro;

  logic        bad_next;
  logic [9:0]  yo_next;
  logic [8:0]  doy_next;
  logic [7:0]  leaps_next;
  logic [TOD_W-1:0] tod_next;
  logic [2:0]  cent;
  logic        leap;
  logic        rdy1;
  logic        rdy2;

  assign rdy2   = !dn.vld || dn_rdy;
  assign rdy1   = !s1_vld || rdy2;
  assign up_rdy = rdy1;

  always_comb begin
    bad_next = (date.year < YEAR_FIRST) || (date.year > YEAR_LAST) ||
               (date.month < 4'd1) || (date.month > 4'd12) || (date.day == 5'd0);
    yo_next  = 10'(date.year - YEAR_FIRST);
    // whole centuries elapsed since 1601
    cent = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (yo_next >= 10'(k * 100)) cent = 3'(k);
    end
    leaps_next = 8'(yo_next[9:2]) - 8'(cent) + 8'(yo_next >= 10'd400);
    leap = (date.year[1:0] == 2'b00) &&
           !(date.year inside {12'd1700, 12'd1800, 12'd1900, 12'd2100, 12'd2200, 12'd2300});
    doy_next = 9'(date.day - 5'd1) + month_offset(date.month) +
               9'(leap && (date.month >= 4'd3));
    tod_next = 17'(date.hour) * SECS_PER_HOUR + 17'(date.minute) * SECS_PER_MIN +
               17'(date.second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (rdy1) begin
      s1_vld   <= up_vld;
      s1_bad   <= bad_next;
      s1_yo    <= yo_next;
      s1_doy   <= doy_next;
      s1_leaps <= leaps_next;
      s1_tod   <= tod_next;
      s1_micro <= date.micro;
    end
  end

  // stage 2: day count since 1601-01-01
  always_ff @(posedge clk) begin
    if (rst) begin
      dn.vld <= 1'b0;
    end else if (rdy2) begin
      dn.vld   <= s1_vld;
      dn.bad   <= s1_bad;
      dn.days  <= 19'(s1_yo) * DAYS_PER_YEAR + 19'(s1_doy) + 19'(s1_leaps);
      dn.tod   <= s1_tod;
      dn.micro <= s1_micro;
    end
  end

endmodule

>>> rtl/ctmc_secs.sv
module ctmc_secs (
  input  logic                clk,
  input  logic                rst,
  input  ctmc_pkg::day_req_t  up,
  output logic                up_rdy,
  output ctmc_pkg::sec_req_t  dn,
  input  logic                dn_rdy
);
  import ctmc_pkg::*;

  logic [DAYS_W+TOD_W-1:0] day_secs;

  assign up_rdy   = !dn.vld || dn_rdy;
  assign day_secs = 36'(up.days) * 36'(DAY_SECONDS);

  // stage 3: seconds since the epoch
  always_ff @(posedge clk) begin
    if (rst) begin
      dn.vld <= 1'b0;
    end else if (up_rdy) begin
      dn.vld   <= up.vld;
      dn.bad   <= up.bad;
      dn.secs  <= SECS_W'(day_secs) + SECS_W'(up.tod);
      dn.micro <= up.micro;
    end
  end

endmodule

>>> rtl/ctmc_scale.sv
module ctmc_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  ctmc_pkg::sec_req_t   up,
  output logic                 up_rdy,
  output logic                 dn_vld,
  input  logic                 dn_rdy,
  output logic [54:0]          stamp,
  output logic                 invalid
);
  import ctmc_pkg::*;

  // stage 4: two partial products of seconds times 10^6
  logic              s4_vld;
  logic              s4_bad;
  logic [SLO_W+19:0] s4_plo;
  logic [SHI_W+19:0] s4_phi;
  logic [19:0]       s4_micro;
  logic              rdy4;
  logic              rdy5;
  logic [STAMP_W-1:0] sum;

  assign rdy5   = !dn_vld || dn_rdy;
  assign rdy4   = !s4_vld || rdy5;
  assign up_rdy = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (rdy4) begin
      s4_vld   <= up.vld;
      s4_bad   <= up.bad;
      s4_plo   <= (SLO_W+20)'(up.secs[SLO_W-1:0]) * (SLO_W+20)'(USEC_PER_SEC);
      s4_phi   <= (SHI_W+20)'(up.secs[SECS_W-1:SLO_W]) * (SHI_W+20)'(USEC_PER_SEC);
      s4_micro <= up.micro;
    end
  end

  assign sum = {s4_phi, {SLO_W{1'b0}}} + STAMP_W'(s4_plo) + STAMP_W'(s4_micro);

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (rdy5) begin
      dn_vld  <= s4_vld;
      invalid <= s4_bad;
      stamp   <= s4_bad ? '0 : sum;
    end
  end

endmodule

>>> rtl/calendar_to_microsecond_count_core.sv
// an accepted request passes all five register stages before its result is on res
// throughput: one request per cycle while res.ready is high, set by the five register
//   stages with a multiplier or adder chain in each
// reset: synchronous active-high rst empties every stage; results in flight are dropped
module calendar_to_microsecond_count_core (
  input logic        clk,
  input logic        rst,
  ctmc_in_if.sink    cal,
  ctmc_out_if.source res
);
  import ctmc_pkg::*;

  date_t    date;
  day_req_t day_req;
  sec_req_t sec_req;
  logic     days_rdy;
  logic     secs_rdy;

  // pack the request fields for the front stages
  assign date.year   = cal.year;
  assign date.month  = cal.month;
  assign date.day    = cal.day;
  assign date.hour   = cal.hour;
  assign date.minute = cal.minute;
  assign date.second = cal.second;
  assign date.micro  = cal.micro;

  // stages 1 and 2: range check, day of year, leap days, time of day
  // in seconds, then day count since the epoch
  ctmc_days u_days (
    .clk    (clk),
    .rst    (rst),
    .up_vld (cal.valid),
    .up_rdy (cal.ready),
    .date   (date),
    .dn     (day_req),
    .dn_rdy (days_rdy)
  );

  // stage 3: days times 86400 plus time of day
  ctmc_secs u_secs (
    .clk    (clk),
    .rst    (rst),
    .up     (day_req),
    .up_rdy (days_rdy),
    .dn     (sec_req),
    .dn_rdy (secs_rdy)
  );

  // stages 4 and 5: seconds times 10^6 split in two partial products,
  // then the final sum with the microseconds into the output register;
  // an out-of-range request leaves with a zero stamp and invalid set
  ctmc_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .up      (sec_req),
    .up_rdy  (secs_rdy),
    .dn_vld  (res.valid),
    .dn_rdy  (res.ready),
    .stamp   (res.stamp),
    .invalid (res.invalid)
  );

endmodule
